[design/kdpt_pkg.sv]
// ----------------------------------------------------------------------------
// kdpt_pkg
// Types and state codes shared by the key double press tracker files.
// ----------------------------------------------------------------------------
package kdpt_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned BSTATE_W = 2;
    localparam int unsigned BSEL_W   = 3;
    localparam int unsigned ENTRY_W  = TIME_W + STATE_W;
    localparam int unsigned KEY_SPAN = 128;
    localparam int unsigned BTN_SPAN = 8;

    localparam logic [TIME_W-1:0] DBL_INTERVAL_RST = 64'd250000000;

    localparam logic [STATE_W-1:0] ST_IDLE        = 3'd0;
    localparam logic [STATE_W-1:0] ST_PRESS       = 3'd1;
    localparam logic [STATE_W-1:0] ST_HOLD        = 3'd2;
    localparam logic [STATE_W-1:0] ST_RELEASE     = 3'd3;
    localparam logic [STATE_W-1:0] ST_LISTEN      = 3'd4;
    localparam logic [STATE_W-1:0] ST_PRESS_DBL   = 3'd5;
    localparam logic [STATE_W-1:0] ST_HOLD_DBL    = 3'd6;
    localparam logic [STATE_W-1:0] ST_RELEASE_DBL = 3'd7;

    localparam logic FUNC_KEY   = 1'b0;
    localparam logic FUNC_MOUSE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] key_index;
        logic               is_down;
        logic [TIME_W-1:0]  now_ns;
    } t_in;

    typedef struct packed {
        logic [STATE_W-1:0] new_state;
        logic               pressed;
        logic               held;
        logic               released;
        logic               double_pressed;
    } t_out;

endpackage

[design/kdpt_ram.sv]
// ----------------------------------------------------------------------------
// kdpt_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/key_double_press_tracker_unit.sv]
// ----------------------------------------------------------------------------
// key_double_press_tracker_unit
// Per-key press/hold/release tracker with double press detection, plus a
// per-mouse-button tracker.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output is not stalled and returns
// one result per transaction, passed through r_s1 and registered in r_out. Key
// state and press start time share one RAM entry that is read on acceptance
// and written back as the transaction leaves r_s1; a forward register covers
// back-to-back hits on the same key, so read-modify-write keeps that rate. Key
// entries start idle after reset through per-entry valid bits, with no
// clearing pass. Indexes at or above KEY_COUNT (key) or BUTTON_COUNT (mouse,
// low three index bits) return idle with all flags clear and change nothing.
// The double interval register is meant to be written only while idle.
// ----------------------------------------------------------------------------
module key_double_press_tracker_unit #(
    parameter int KEY_COUNT    = 128,
    parameter int BUTTON_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  kdpt_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output kdpt_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [kdpt_pkg::TIME_W-1:0]   i_cfg_wdata
);

    localparam int KEY_DEPTH = (KEY_COUNT < kdpt_pkg::KEY_SPAN) ?
                               KEY_COUNT : kdpt_pkg::KEY_SPAN;
    localparam int BTN_DEPTH = (BUTTON_COUNT < kdpt_pkg::BTN_SPAN) ?
                               BUTTON_COUNT : kdpt_pkg::BTN_SPAN;
    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int BAW = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;

    logic [kdpt_pkg::TIME_W-1:0]   r_interval;
    logic                          r_s1_vld;
    kdpt_pkg::t_in                 r_s1;
    logic                          r_s1_kvld;
    logic                          r_fwd_hit;
    logic [kdpt_pkg::ENTRY_W-1:0]  r_fwd_data;
    logic [KEY_DEPTH-1:0]          r_kvld;
    logic [kdpt_pkg::BSTATE_W-1:0] r_btn [BTN_DEPTH];
    logic                          r_out_vld;
    kdpt_pkg::t_out                r_out;

    logic                          out_free;
    logic                          s1_adv;
    logic                          in_acc;
    logic [KAW-1:0]                rd_addr;
    logic [KAW-1:0]                wr_addr;
    logic                          wr_en;
    logic [kdpt_pkg::ENTRY_W-1:0]  wr_data;
    logic [kdpt_pkg::ENTRY_W-1:0]  rd_data;
    logic [kdpt_pkg::ENTRY_W-1:0]  cur_entry;
    logic [kdpt_pkg::STATE_W-1:0]  cur_st;
    logic [kdpt_pkg::TIME_W-1:0]   cur_start;
    logic [kdpt_pkg::TIME_W-1:0]   gap;
    logic                          dbl_ok;
    logic [kdpt_pkg::STATE_W-1:0]  key_nxt;
    logic [kdpt_pkg::TIME_W-1:0]   start_nxt;
    logic                          key_in;
    logic [kdpt_pkg::BSEL_W-1:0]   bsel;
    logic [BAW-1:0]                bidx;
    logic                          btn_in;
    logic [kdpt_pkg::BSTATE_W-1:0] cur_b;
    logic [kdpt_pkg::BSTATE_W-1:0] btn_nxt;
    logic                          btn_we;
    logic [kdpt_pkg::STATE_W-1:0]  res_st;
    kdpt_pkg::t_out                n_out;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign rd_addr = i_in_data.key_index[KAW-1:0];
    assign wr_addr = r_s1.key_index[KAW-1:0];

    kdpt_ram #(
        .WIDTH (kdpt_pkg::ENTRY_W),
        .DEPTH (KEY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // key path
    assign key_in    = (r_s1.func == kdpt_pkg::FUNC_KEY) &&
                       (int'(r_s1.key_index) < KEY_COUNT);
    assign cur_entry = r_fwd_hit ? r_fwd_data : rd_data;
    assign cur_st    = (r_fwd_hit || r_s1_kvld) ?
                       cur_entry[kdpt_pkg::STATE_W-1:0] : kdpt_pkg::ST_IDLE;
    assign cur_start = cur_entry[kdpt_pkg::ENTRY_W-1:kdpt_pkg::STATE_W];
    assign gap       = r_s1.now_ns - cur_start;
    assign dbl_ok    = (gap <= r_interval);

    always_comb begin
        key_nxt   = cur_st;
        start_nxt = cur_start;
        case (cur_st)
            kdpt_pkg::ST_IDLE: begin
                if (r_s1.is_down) begin
                    key_nxt   = kdpt_pkg::ST_PRESS;
                    start_nxt = r_s1.now_ns;
                end
            end
            kdpt_pkg::ST_PRESS: begin
                key_nxt = r_s1.is_down ? kdpt_pkg::ST_HOLD : kdpt_pkg::ST_RELEASE;
            end
            kdpt_pkg::ST_HOLD: begin
                if (!r_s1.is_down) begin
                    key_nxt = kdpt_pkg::ST_RELEASE;
                end
            end
            kdpt_pkg::ST_RELEASE: begin
                key_nxt = kdpt_pkg::ST_LISTEN;
            end
            kdpt_pkg::ST_LISTEN: begin
                if (r_s1.is_down) begin
                    if (dbl_ok) begin
                        key_nxt = kdpt_pkg::ST_PRESS_DBL;
                    end else begin
                        key_nxt   = kdpt_pkg::ST_PRESS;
                        start_nxt = r_s1.now_ns;
                    end
                end
            end
            kdpt_pkg::ST_PRESS_DBL: begin
                key_nxt = r_s1.is_down ? kdpt_pkg::ST_HOLD_DBL :
                                         kdpt_pkg::ST_RELEASE_DBL;
            end
            kdpt_pkg::ST_HOLD_DBL: begin
                if (!r_s1.is_down) begin
                    key_nxt = kdpt_pkg::ST_RELEASE_DBL;
                end
            end
            kdpt_pkg::ST_RELEASE_DBL: begin
                key_nxt = kdpt_pkg::ST_IDLE;
            end
            default: begin
                key_nxt = cur_st;
            end
        endcase
    end

    assign wr_en   = s1_adv && key_in;
    assign wr_data = {start_nxt, key_nxt};

    // mouse path
    assign bsel   = r_s1.key_index[kdpt_pkg::BSEL_W-1:0];
    assign bidx   = bsel[BAW-1:0];
    assign btn_in = (r_s1.func == kdpt_pkg::FUNC_MOUSE) && (int'(bsel) < BUTTON_COUNT);
    assign cur_b  = r_btn[bidx];
    assign btn_we = s1_adv && btn_in;

    always_comb begin
        btn_nxt = cur_b;
        if (r_s1.is_down && cur_b == kdpt_pkg::ST_IDLE[kdpt_pkg::BSTATE_W-1:0]) begin
            btn_nxt = kdpt_pkg::ST_PRESS[kdpt_pkg::BSTATE_W-1:0];
        end else if (!r_s1.is_down &&
                     (cur_b == kdpt_pkg::ST_PRESS[kdpt_pkg::BSTATE_W-1:0] ||
                      cur_b == kdpt_pkg::ST_HOLD[kdpt_pkg::BSTATE_W-1:0])) begin
            btn_nxt = kdpt_pkg::ST_RELEASE[kdpt_pkg::BSTATE_W-1:0];
        end else if (cur_b == kdpt_pkg::ST_PRESS[kdpt_pkg::BSTATE_W-1:0]) begin
            btn_nxt = kdpt_pkg::ST_HOLD[kdpt_pkg::BSTATE_W-1:0];
        end else if (cur_b == kdpt_pkg::ST_RELEASE[kdpt_pkg::BSTATE_W-1:0]) begin
            btn_nxt = kdpt_pkg::ST_IDLE[kdpt_pkg::BSTATE_W-1:0];
        end
    end

    // result
    always_comb begin
        if (key_in) begin
            res_st = key_nxt;
        end else if (btn_in) begin
            res_st = {1'b0, btn_nxt};
        end else begin
            res_st = kdpt_pkg::ST_IDLE;
        end
        n_out.new_state      = res_st;
        n_out.pressed        = (res_st == kdpt_pkg::ST_PRESS) ||
                               (res_st == kdpt_pkg::ST_PRESS_DBL);
        n_out.held           = (res_st == kdpt_pkg::ST_HOLD) ||
                               (res_st == kdpt_pkg::ST_HOLD_DBL);
        n_out.released       = (res_st == kdpt_pkg::ST_RELEASE) ||
                               (res_st == kdpt_pkg::ST_RELEASE_DBL);
        n_out.double_pressed = key_in && (res_st == kdpt_pkg::ST_PRESS_DBL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= kdpt_pkg::DBL_INTERVAL_RST;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_kvld     <= '0;
            for (int i = 0; i < BTN_DEPTH; i++) begin
                r_btn[i] <= kdpt_pkg::ST_IDLE[kdpt_pkg::BSTATE_W-1:0];
            end
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_kvld[wr_addr] <= 1'b1;
            end
            if (btn_we) begin
                r_btn[bidx] <= btn_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1       <= i_in_data;
            r_s1_kvld  <= r_kvld[rd_addr];
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[design/kdpt_checker.sv]
// ----------------------------------------------------------------------------
// kdpt_checker
// Port-level checks for the key double press tracker, bound to the top level.
// ----------------------------------------------------------------------------
module kdpt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  kdpt_pkg::t_out              o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |-> ##2 o_out_valid)
        else $error("accepted transaction did not reach output");

endmodule

bind key_double_press_tracker_unit kdpt_checker u_kdpt_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for key_double_press_tracker_unit.
// ----------------------------------------------------------------------------
// Sends key and mouse button samples through the valid/stall input channel
// and checks every result against a state tracker kept alongside the block.
// The tracker follows per-key state, per-key press start time and per-button
// state, and predicts each result when its sample is accepted. Directed cases
// cover a full double press lifecycle, the interval boundary, time wrap, time
// going backwards, the interval extremes and the mouse path. Random traffic
// then runs in three idling profiles with different intervals, plus one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 340;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    kdpt_pkg::t_in               in_data   = '0;
    logic                        out_stall = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [kdpt_pkg::TIME_W-1:0] cfg_wdata = '0;
    logic                        in_stall;
    logic                        out_valid;
    kdpt_pkg::t_out              out_data;

    // tracker state
    logic [kdpt_pkg::STATE_W-1:0]  key_state   [kdpt_pkg::KEY_SPAN];
    logic [kdpt_pkg::TIME_W-1:0]   press_start [kdpt_pkg::KEY_SPAN];
    logic [kdpt_pkg::BSTATE_W-1:0] btn_state   [kdpt_pkg::BTN_SPAN];
    logic [kdpt_pkg::TIME_W-1:0]   dbl_interval;

    kdpt_pkg::t_out state_reports_q[$];

    int                           send_idle_pct  = 0;
    int                           recv_stall_pct = 0;
    int                           holdoff_left   = 0;
    int                           quiet_cycles   = 0;
    int                           fail_count     = 0;
    int                           samples_sent   = 0;
    int                           results_seen   = 0;
    int                           doubles_seen   = 0;
    int                           intervals_set  = 0;
    logic [63:0]                  clock_ns       = '0;
    logic [kdpt_pkg::INDEX_W-1:0] key_pool[4];

    key_double_press_tracker_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic logic [kdpt_pkg::INDEX_W-1:0] rand_index();
        int unsigned r;
        r = $urandom_range(0, kdpt_pkg::KEY_SPAN - 1);
        return r[kdpt_pkg::INDEX_W-1:0];
    endfunction

    function automatic kdpt_pkg::t_out track_sample(input kdpt_pkg::t_in s);
        kdpt_pkg::t_out               res;
        logic [kdpt_pkg::STATE_W-1:0] cur;
        logic [kdpt_pkg::STATE_W-1:0] nxt;
        logic [kdpt_pkg::TIME_W-1:0]  gap;
        logic                         key_path;
        int                           idx;
        int                           btn;
        nxt      = kdpt_pkg::ST_IDLE;
        key_path = 1'b0;
        if (s.func == kdpt_pkg::FUNC_KEY) begin
            idx = int'(s.key_index);
            if (idx < kdpt_pkg::KEY_SPAN) begin
                cur = key_state[idx];
                gap = s.now_ns - press_start[idx];
                if (s.is_down && cur == kdpt_pkg::ST_IDLE) begin
                    press_start[idx] = s.now_ns;
                    nxt = kdpt_pkg::ST_PRESS;
                end else if (s.is_down && cur == kdpt_pkg::ST_LISTEN) begin
                    if (gap <= dbl_interval) begin
                        nxt = kdpt_pkg::ST_PRESS_DBL;
                    end else begin
                        press_start[idx] = s.now_ns;
                        nxt = kdpt_pkg::ST_PRESS;
                    end
                end else if (!s.is_down && (cur == kdpt_pkg::ST_PRESS ||
                                            cur == kdpt_pkg::ST_HOLD)) begin
                    nxt = kdpt_pkg::ST_RELEASE;
                end else if (!s.is_down && (cur == kdpt_pkg::ST_PRESS_DBL ||
                                            cur == kdpt_pkg::ST_HOLD_DBL)) begin
                    nxt = kdpt_pkg::ST_RELEASE_DBL;
                end else begin
                    case (cur)
                        kdpt_pkg::ST_PRESS:       nxt = kdpt_pkg::ST_HOLD;
                        kdpt_pkg::ST_RELEASE:     nxt = kdpt_pkg::ST_LISTEN;
                        kdpt_pkg::ST_PRESS_DBL:   nxt = kdpt_pkg::ST_HOLD_DBL;
                        kdpt_pkg::ST_RELEASE_DBL: nxt = kdpt_pkg::ST_IDLE;
                        default:                  nxt = cur;
                    endcase
                end
                key_state[idx] = nxt;
                key_path       = 1'b1;
            end
        end else begin
            btn = int'(s.key_index[kdpt_pkg::BSEL_W-1:0]);
            if (btn < kdpt_pkg::BTN_SPAN) begin
                cur = {1'b0, btn_state[btn]};
                if (s.is_down && cur == kdpt_pkg::ST_IDLE) begin
                    nxt = kdpt_pkg::ST_PRESS;
                end else if (!s.is_down && (cur == kdpt_pkg::ST_PRESS ||
                                            cur == kdpt_pkg::ST_HOLD)) begin
                    nxt = kdpt_pkg::ST_RELEASE;
                end else if (cur == kdpt_pkg::ST_PRESS) begin
                    nxt = kdpt_pkg::ST_HOLD;
                end else if (cur == kdpt_pkg::ST_RELEASE) begin
                    nxt = kdpt_pkg::ST_IDLE;
                end else begin
                    nxt = cur;
                end
                btn_state[btn] = nxt[kdpt_pkg::BSTATE_W-1:0];
            end
        end
        res.new_state      = nxt;
        res.pressed        = (nxt == kdpt_pkg::ST_PRESS) || (nxt == kdpt_pkg::ST_PRESS_DBL);
        res.held           = (nxt == kdpt_pkg::ST_HOLD) || (nxt == kdpt_pkg::ST_HOLD_DBL);
        res.released       = (nxt == kdpt_pkg::ST_RELEASE) ||
                             (nxt == kdpt_pkg::ST_RELEASE_DBL);
        res.double_pressed = key_path && (nxt == kdpt_pkg::ST_PRESS_DBL);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            out_stall <= 1'b1;
            holdoff_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin : monitor
        kdpt_pkg::t_out want;
        logic           moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && !in_stall) begin
                want = track_sample(in_data);
                if (want.double_pressed) doubles_seen++;
                state_reports_q.push_back(want);
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (state_reports_q.size() == 0) begin
                    $error("result with no pending transaction: state %0d",
                           out_data.new_state);
                    fail_count++;
                end else begin
                    want = state_reports_q.pop_front();
                    check_field("new_state", 32'(want.new_state),
                                32'(out_data.new_state));
                    check_field("pressed", 32'(want.pressed), 32'(out_data.pressed));
                    check_field("held", 32'(want.held), 32'(out_data.held));
                    check_field("released", 32'(want.released), 32'(out_data.released));
                    check_field("double_pressed", 32'(want.double_pressed),
                                32'(out_data.double_pressed));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_txn(input logic func, input logic [kdpt_pkg::INDEX_W-1:0] idx,
                            input logic down, input logic [kdpt_pkg::TIME_W-1:0] now);
        kdpt_pkg::t_in txn;
        txn.func      = func;
        txn.key_index = idx;
        txn.is_down   = down;
        txn.now_ns    = now;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= txn;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        samples_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (state_reports_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_interval(input logic [kdpt_pkg::TIME_W-1:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        dbl_interval  = value;
        intervals_set++;
    endtask

    task automatic send_tap_pair(input logic [kdpt_pkg::INDEX_W-1:0] idx,
                                 input logic [63:0] step);
        logic down;
        for (int i = 0; i < 6; i++) begin
            down     = (i % 3 == 0);
            clock_ns = clock_ns + 64'($urandom_range(0, 32'(step)));
            send_txn(kdpt_pkg::FUNC_KEY, idx, down, clock_ns);
        end
    endtask

    task automatic send_random_samples(input int count, input logic [63:0] step);
        int                           left;
        logic                         func;
        logic [kdpt_pkg::INDEX_W-1:0] idx;
        left = count;
        foreach (key_pool[i]) key_pool[i] = rand_index();
        clock_ns = {$urandom, $urandom};
        while (left > 0) begin
            if (left >= 6 && $urandom_range(0, 7) == 0) begin
                send_tap_pair(key_pool[$urandom_range(0, 3)], step);
                left -= 6;
            end else begin
                func = ($urandom_range(0, 99) < 20) ? kdpt_pkg::FUNC_MOUSE :
                                                      kdpt_pkg::FUNC_KEY;
                if (func == kdpt_pkg::FUNC_MOUSE || $urandom_range(0, 9) == 0)
                    idx = rand_index();
                else
                    idx = key_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 39) == 0)
                    clock_ns = {$urandom, $urandom};
                else
                    clock_ns = clock_ns + 64'($urandom_range(0, 32'(step)));
                send_txn(func, idx, 1'($urandom_range(0, 1)), clock_ns);
                left--;
            end
        end
    endtask

    task automatic test_key_lifecycle();
        logic [63:0] t0;
        t0 = 64'd1000;
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b1, t0);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b1, t0 + 64'd10);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b0, t0 + 64'd20);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b0, t0 + 64'd30);
        // second press lands exactly on the interval
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b1, t0 + kdpt_pkg::DBL_INTERVAL_RST);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b1,
                 t0 + kdpt_pkg::DBL_INTERVAL_RST + 64'd10);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b0,
                 t0 + kdpt_pkg::DBL_INTERVAL_RST + 64'd20);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd0, 1'b0,
                 t0 + kdpt_pkg::DBL_INTERVAL_RST + 64'd30);
    endtask

    task automatic test_time_edges();
        // press start near the top of the time range, second press after wrap
        send_txn(kdpt_pkg::FUNC_KEY, 7'd127, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd127, 1'b0, 64'hFFFF_FFFF_FFFF_FFF8);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd127, 1'b0, 64'hFFFF_FFFF_FFFF_FFFC);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd127, 1'b1, 64'd4);
        // time going backwards
        send_txn(kdpt_pkg::FUNC_KEY, 7'h55, 1'b1, 64'd5000);
        send_txn(kdpt_pkg::FUNC_KEY, 7'h55, 1'b0, 64'd5100);
        send_txn(kdpt_pkg::FUNC_KEY, 7'h55, 1'b0, 64'd5200);
        send_txn(kdpt_pkg::FUNC_KEY, 7'h55, 1'b1, 64'd4000);
    endtask

    task automatic test_mouse_buttons();
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h7F, 1'b1, 64'd0);
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h7F, 1'b1, 64'd0);
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h07, 1'b0, '1);
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h7F, 1'b0, '1);
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h0F, 1'b0, 64'd1);
        send_txn(kdpt_pkg::FUNC_MOUSE, 7'h08, 1'b1, 64'd2);
    endtask

    task automatic test_interval_extremes();
        logic [63:0] t;
        t = {$urandom, $urandom};
        write_interval('0);
        for (int i = 0; i < 4; i++) send_txn(kdpt_pkg::FUNC_KEY, 7'd9, i != 1 && i != 2, t);
        for (int i = 0; i < 3; i++) send_txn(kdpt_pkg::FUNC_KEY, 7'd10, i == 0, t);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd10, 1'b1, t + 64'd1);
        write_interval('1);
        for (int i = 0; i < 3; i++) send_txn(kdpt_pkg::FUNC_KEY, 7'd11, i == 0, t);
        send_txn(kdpt_pkg::FUNC_KEY, 7'd11, 1'b1, t - 64'd1);
    endtask

    task automatic test_random_phase(input int sender_pct, input int receiver_pct);
        logic [63:0] interval;
        interval = 64'($urandom_range(1000, 2000000));
        write_interval(interval);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        send_random_samples(PHASE_ITEMS, interval / 16 + 1);
    endtask

    task automatic test_output_holdoff();
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 250;
        send_random_samples(40, 64'd5000);
        wait_for_drain();
    endtask

    initial begin
        foreach (key_state[i]) key_state[i] = kdpt_pkg::ST_IDLE;
        foreach (press_start[i]) press_start[i] = '0;
        foreach (btn_state[i]) btn_state[i] = kdpt_pkg::ST_IDLE[kdpt_pkg::BSTATE_W-1:0];
        dbl_interval = kdpt_pkg::DBL_INTERVAL_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 22;
        recv_stall_pct = 66;
        test_key_lifecycle();
        test_time_edges();
        test_mouse_buttons();
        test_interval_extremes();
        test_random_phase(22, 66);
        test_random_phase(66, 22);
        test_random_phase(0, 0);
        test_output_holdoff();
        write_interval(kdpt_pkg::DBL_INTERVAL_RST);
        wait_for_drain();
        repeat (5) @(posedge clk);

        $display("Run: %0d samples sent, %0d results checked, %0d double presses",
                 samples_sent, results_seen, doubles_seen);
        $display("Run: %0d interval settings incl. zero and all ones, 3 idling profiles",
                 intervals_set);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
